>>> sv/egcd_pkg.sv
// Shared types and constants for the extended gcd block.
// Used by egcd_ctrl, egcd_dpath and extended_gcd_floor_div; no dependencies.
`timescale 1ns / 1ps

package egcd_pkg;

  localparam int unsigned DATA_WIDTH = 64;  // default arithmetic width
  localparam int unsigned FIELD_W    = 64;  // operand and coefficient port width
  localparam int unsigned GCD_W      = 63;  // gcd port width

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ALIGN,
    ST_DIVIDE,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // take a new operand pair
    logic setup;     // latch magnitudes for the next division
    logic shift;     // align divisor one bit further left
    logic divide;    // one restoring-division step
    logic update;    // advance the remainder sequence
    logic load_out;  // fix signs and fill the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cur_zero;   // current remainder is zero
    logic can_shift;  // doubled divisor still fits under the dividend
    logic last;       // final quotient bit this cycle
  } sts_t;

endpackage

>>> sv/egcd_ctrl.sv
// Sequencer for the extended gcd block: handshakes and step ordering.
// Depends on egcd_pkg; drives egcd_dpath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module egcd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  egcd_pkg::sts_t    sts_i,
  output egcd_pkg::cmd_t    cmd_o
);

  egcd_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      egcd_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = egcd_pkg::ST_CHECK;
      end
      egcd_pkg::ST_CHECK: begin
        state_d = sts_i.cur_zero ? egcd_pkg::ST_FINISH : egcd_pkg::ST_ALIGN;
      end
      egcd_pkg::ST_ALIGN: begin
        if (!sts_i.can_shift) state_d = egcd_pkg::ST_DIVIDE;
      end
      egcd_pkg::ST_DIVIDE: begin
        if (sts_i.last) state_d = egcd_pkg::ST_UPDATE;
      end
      egcd_pkg::ST_UPDATE: begin
        state_d = egcd_pkg::ST_CHECK;
      end
      egcd_pkg::ST_FINISH: begin
        if (out_free) state_d = egcd_pkg::ST_IDLE;
      end
      default: state_d = egcd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      egcd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      egcd_pkg::ST_CHECK:  cmd_o.setup    = !sts_i.cur_zero;
      egcd_pkg::ST_ALIGN:  cmd_o.shift    = sts_i.can_shift;
      egcd_pkg::ST_DIVIDE: cmd_o.divide   = 1'b1;
      egcd_pkg::ST_UPDATE: cmd_o.update   = 1'b1;
      egcd_pkg::ST_FINISH: cmd_o.load_out = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= egcd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> sv/egcd_dpath.sv
// Datapath for the extended gcd block: remainder/coefficient registers,
// shift-subtract divider with Horner accumulation of q*s and q*t, output register.
// Depends on egcd_pkg; commanded by egcd_ctrl.
`timescale 1ns / 1ps

module egcd_dpath #(
  parameter int unsigned DATA_WIDTH = egcd_pkg::DATA_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  egcd_pkg::cmd_t                       cmd_i,
  output egcd_pkg::sts_t                       sts_o,
  input  logic signed [egcd_pkg::FIELD_W-1:0]  first_value_i,
  input  logic signed [egcd_pkg::FIELD_W-1:0]  second_value_i,
  output logic signed [egcd_pkg::FIELD_W-1:0]  coef_first_o,
  output logic signed [egcd_pkg::FIELD_W-1:0]  coef_second_o,
  output logic        [egcd_pkg::GCD_W-1:0]    divisor_out_o
);

  // Remainders carry one guard bit so |min| fits, except at full field width
  // where the arithmetic wraps exactly as two's complement.
  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned RW = (DW < egcd_pkg::FIELD_W) ? DW + 1 : egcd_pkg::FIELD_W;
  localparam int unsigned CW = $clog2(RW);

  logic [RW-1:0] prev_r_q, prev_r_d, cur_r_q, cur_r_d;
  logic [DW-1:0] prev_s_q, prev_s_d, cur_s_q, cur_s_d;
  logic [DW-1:0] prev_t_q, prev_t_d, cur_t_q, cur_t_d;
  logic [RW-1:0] rem_q, rem_d, dsh_q, dsh_d, dmag_q, dmag_d;
  logic [DW-1:0] acc_s_q, acc_s_d, acc_t_q, acc_t_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ns_q, ns_d, ds_q, ds_d;
  logic signed [egcd_pkg::FIELD_W-1:0] coef_first_q, coef_first_d;
  logic signed [egcd_pkg::FIELD_W-1:0] coef_second_q, coef_second_d;
  logic [egcd_pkg::GCD_W-1:0]          gcd_q, gcd_d;

  logic signed [DW-1:0] a_in, b_in;
  logic [RW-1:0] un, ud;
  logic          ge, diff_sign, ra_nz, neg;
  logic [RW-1:0] rmag, nxt_r, g_full;
  logic [DW-1:0] nxt_s, nxt_t, s_fix, t_fix;

  assign a_in = first_value_i[DW-1:0];
  assign b_in = second_value_i[DW-1:0];

  assign un = prev_r_q[RW-1] ? (RW'(0) - prev_r_q) : prev_r_q;
  assign ud = cur_r_q[RW-1]  ? (RW'(0) - cur_r_q)  : cur_r_q;

  assign ge        = (rem_q >= dsh_q);
  assign diff_sign = ns_q ^ ds_q;
  assign ra_nz     = (rem_q != '0);

  // Floor remainder from the magnitude remainder; q*s, q*t from qa*s, qa*t.
  assign rmag  = (diff_sign && ra_nz) ? (dmag_q - rem_q) : rem_q;
  assign nxt_r = ds_q ? (RW'(0) - rmag) : rmag;

  always_comb begin
    if (!diff_sign) begin
      nxt_s = prev_s_q - acc_s_q;
      nxt_t = prev_t_q - acc_t_q;
    end else if (!ra_nz) begin
      nxt_s = prev_s_q + acc_s_q;
      nxt_t = prev_t_q + acc_t_q;
    end else begin
      nxt_s = prev_s_q + acc_s_q + cur_s_q;
      nxt_t = prev_t_q + acc_t_q + cur_t_q;
    end
  end

  assign neg    = prev_r_q[RW-1];
  assign g_full = neg ? (RW'(0) - prev_r_q) : prev_r_q;
  assign s_fix  = neg ? (DW'(0) - prev_s_q) : prev_s_q;
  assign t_fix  = neg ? (DW'(0) - prev_t_q) : prev_t_q;

  assign sts_o.cur_zero  = (cur_r_q == '0);
  assign sts_o.can_shift = ({dsh_q, 1'b0} <= {1'b0, rem_q});
  assign sts_o.last      = (cnt_q == '0);

  always_comb begin
    prev_r_d = prev_r_q;
    cur_r_d  = cur_r_q;
    prev_s_d = prev_s_q;
    cur_s_d  = cur_s_q;
    prev_t_d = prev_t_q;
    cur_t_d  = cur_t_q;
    rem_d    = rem_q;
    dsh_d    = dsh_q;
    dmag_d   = dmag_q;
    acc_s_d  = acc_s_q;
    acc_t_d  = acc_t_q;
    cnt_d    = cnt_q;
    ns_d     = ns_q;
    ds_d     = ds_q;
    coef_first_d  = coef_first_q;
    coef_second_d = coef_second_q;
    gcd_d         = gcd_q;

    if (cmd_i.load) begin
      prev_r_d = RW'(a_in);
      cur_r_d  = RW'(b_in);
      prev_s_d = DW'(1);
      cur_s_d  = '0;
      prev_t_d = '0;
      cur_t_d  = DW'(1);
    end
    if (cmd_i.setup) begin
      rem_d   = un;
      dsh_d   = ud;
      dmag_d  = ud;
      ns_d    = prev_r_q[RW-1];
      ds_d    = cur_r_q[RW-1];
      acc_s_d = '0;
      acc_t_d = '0;
      cnt_d   = '0;
    end
    if (cmd_i.shift) begin
      dsh_d = {dsh_q[RW-2:0], 1'b0};
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.divide) begin
      // quotient bits come MSB first: acc = 2*acc + bit*coef
      if (ge) begin
        rem_d   = rem_q - dsh_q;
        acc_s_d = {acc_s_q[DW-2:0], 1'b0} + cur_s_q;
        acc_t_d = {acc_t_q[DW-2:0], 1'b0} + cur_t_q;
      end else begin
        acc_s_d = {acc_s_q[DW-2:0], 1'b0};
        acc_t_d = {acc_t_q[DW-2:0], 1'b0};
      end
      dsh_d = {1'b0, dsh_q[RW-1:1]};
      cnt_d = cnt_q - CW'(1);
    end
    if (cmd_i.update) begin
      prev_r_d = cur_r_q;
      cur_r_d  = nxt_r;
      prev_s_d = cur_s_q;
      cur_s_d  = nxt_s;
      prev_t_d = cur_t_q;
      cur_t_d  = nxt_t;
    end
    if (cmd_i.load_out) begin
      coef_first_d  = egcd_pkg::FIELD_W'(s_fix);
      coef_second_d = egcd_pkg::FIELD_W'(t_fix);
      gcd_d         = egcd_pkg::GCD_W'(g_full[DW-2:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_r_q <= '0;
      cur_r_q  <= '0;
      prev_s_q <= '0;
      cur_s_q  <= '0;
      prev_t_q <= '0;
      cur_t_q  <= '0;
      rem_q    <= '0;
      dsh_q    <= '0;
      dmag_q   <= '0;
      acc_s_q  <= '0;
      acc_t_q  <= '0;
      cnt_q    <= '0;
      ns_q     <= 1'b0;
      ds_q     <= 1'b0;
      coef_first_q  <= '0;
      coef_second_q <= '0;
      gcd_q         <= '0;
    end else begin
      prev_r_q <= prev_r_d;
      cur_r_q  <= cur_r_d;
      prev_s_q <= prev_s_d;
      cur_s_q  <= cur_s_d;
      prev_t_q <= prev_t_d;
      cur_t_q  <= cur_t_d;
      rem_q    <= rem_d;
      dsh_q    <= dsh_d;
      dmag_q   <= dmag_d;
      acc_s_q  <= acc_s_d;
      acc_t_q  <= acc_t_d;
      cnt_q    <= cnt_d;
      ns_q     <= ns_d;
      ds_q     <= ds_d;
      coef_first_q  <= coef_first_d;
      coef_second_q <= coef_second_d;
      gcd_q         <= gcd_d;
    end
  end

  assign coef_first_o  = coef_first_q;
  assign coef_second_o = coef_second_q;
  assign divisor_out_o = gcd_q;

endmodule

>>> sv/extended_gcd_floor_div.sv
// Extended gcd with floor division: (a, b) -> (s, t, g), a*s + b*t = g >= 0.
// From accept to out_valid_o, each remainder step runs check, align, shift-subtract divide and
// update, with the one-bit-per-cycle align and divider; a zero remainder goes on to finish.
// One transaction in flight; the next is accepted while a result waits in the output
// register. Reset (rst_ni low, async) returns to idle, no output.
`timescale 1ns / 1ps

module extended_gcd_floor_div #(
  parameter int unsigned DATA_WIDTH = egcd_pkg::DATA_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [egcd_pkg::FIELD_W-1:0]  first_value_i,
  input  logic signed [egcd_pkg::FIELD_W-1:0]  second_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [egcd_pkg::FIELD_W-1:0]  coef_first_o,
  output logic signed [egcd_pkg::FIELD_W-1:0]  coef_second_o,
  output logic        [egcd_pkg::GCD_W-1:0]    divisor_out_o
);

  egcd_pkg::cmd_t cmd;
  egcd_pkg::sts_t sts;

  egcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  egcd_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .coef_first_o   (coef_first_o),
    .coef_second_o  (coef_second_o),
    .divisor_out_o  (divisor_out_o)
  );

  // at most one datapath operation per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("multiple datapath commands in one cycle");

  // accepted transaction closes the input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // last quotient bit is followed by the sequence update
  a_div_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.divide && sts.last |=> cmd.update)
    else $error("division end not followed by update");

  // loading the output register raises valid
  a_load_out_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("result loaded without valid");

endmodule
